[design/sitp_pkg.sv]
package sitp_pkg;

    // default table limits
    localparam int MAX_DENSITY_ROWS_DEF    = 8;
    localparam int MAX_MOISTURE_POINTS_DEF = 8;

    // field widths
    localparam int WORD_W  = 16;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 4;

    // step unit widths: values, signed differences, product magnitude, result
    localparam int VAL_W   = 36;
    localparam int NUM_W   = WORD_W + 1;
    localparam int MAG_W   = VAL_W + NUM_W - 1;
    localparam int RES_W   = MAG_W + 2;

    // item queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes and reset value
    localparam logic CFG_DENSITY_ROWS   = 1'b0;
    localparam logic CFG_MOISTURE_PTS   = 1'b1;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef enum logic [KIND_W-1:0] {
        KIND_COMPUTE    = 2'd0,
        KIND_WR_BREAK   = 2'd1,
        KIND_WR_DENSITY = 2'd2,
        KIND_WR_IMPED   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SAT   = 2'd1,
        ST_FAULT = 2'd2,
        ST_WRITE = 2'd3
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   table_row;
        logic [IDX_W-1:0]   table_col;
        logic [WORD_W-1:0]  table_word;
        logic [WORD_W-1:0]  bulk_density;
        logic [WORD_W-1:0]  water_content;
    } item_t;

    // one interpolation step: a - (a - b) * n / d
    typedef struct packed {
        logic                    start;
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
        logic signed [NUM_W-1:0] n;
        logic signed [NUM_W-1:0] d;
    } step_req_t;

    typedef struct packed {
        logic                    done;
        logic                    fault;
        logic signed [RES_W-1:0] res;
    } step_resp_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_DONE
    } step_state_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DISPATCH,
        BK_RATIO,
        BK_DS_RD,
        BK_DS_CMP,
        BK_MS_RD,
        BK_MS_CMP,
        BK_FETCH,
        BK_EVAL,
        BK_STEP_P,
        BK_STEP_Q,
        BK_STEP_LAST
    } back_state_t;

    // fetched operand slots
    localparam int FE_COUNT = 9;
    localparam int FE_W     = 4;
    localparam logic [FE_W-1:0] FE_G0     = 4'd0;
    localparam logic [FE_W-1:0] FE_G1     = 4'd1;
    localparam logic [FE_W-1:0] FE_M_J0I0 = 4'd2;
    localparam logic [FE_W-1:0] FE_M_J0I1 = 4'd3;
    localparam logic [FE_W-1:0] FE_M_J1I1 = 4'd4;
    localparam logic [FE_W-1:0] FE_T_J0I0 = 4'd5;
    localparam logic [FE_W-1:0] FE_T_J0I1 = 4'd6;
    localparam logic [FE_W-1:0] FE_T_J1I0 = 4'd7;
    localparam logic [FE_W-1:0] FE_T_J1I1 = 4'd8;
    localparam logic [FE_W-1:0] FE_END    = 4'd9;

    // signed difference of two unsigned words
    function automatic logic signed [NUM_W-1:0] word_diff(input logic [WORD_W-1:0] x,
                                                          input logic [WORD_W-1:0] y);
        word_diff = $signed({1'b0, x}) - $signed({1'b0, y});
    endfunction

    // unsigned word widened to a step value
    function automatic logic signed [VAL_W-1:0] word_val(input logic [WORD_W-1:0] x);
        word_val = $signed({{(VAL_W-WORD_W){1'b0}}, x});
    endfunction

endpackage

[design/sitp_front.sv]
module sitp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  sitp_pkg::item_t in_item,
    output sitp_pkg::item_t q_item,
    output logic            q_valid,
    input  logic            q_pop
);
    import sitp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    logic               pop;

    // accept while the queue has room
    assign busy    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_item  = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[design/sitp_step.sv]
module sitp_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sitp_pkg::step_req_t  req,
    output sitp_pkg::step_resp_t resp
);
    import sitp_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);

    step_state_t             state_reg, state_next;
    logic [MAG_W-1:0]        xsh_reg;
    logic [NUM_W-2:0]        nmag_reg;
    logic [NUM_W-2:0]        dmag_reg;
    logic [MAG_W-1:0]        acc_reg;
    logic [NUM_W-1:0]        rem_reg;
    logic signed [VAL_W-1:0] a_reg;
    logic                    neg_reg;
    logic                    fault_reg;
    logic [CNT_W-1:0]        cnt_reg;

    logic                    take;
    logic signed [VAL_W-1:0] diff;
    logic [VAL_W-1:0]        diff_mag;
    logic [NUM_W-1:0]        n_abs;
    logic [NUM_W-1:0]        d_abs;
    logic [NUM_W-1:0]        rem_sh;
    logic                    rem_ge;
    logic signed [RES_W-1:0] quot;

    assign take     = req.start && (state_reg == MD_IDLE || state_reg == MD_DONE);
    assign diff     = req.a - req.b;
    assign diff_mag = diff[VAL_W-1] ? VAL_W'(-diff) : VAL_W'(diff);
    assign n_abs    = req.n[NUM_W-1] ? NUM_W'(-req.n) : NUM_W'(req.n);
    assign d_abs    = req.d[NUM_W-1] ? NUM_W'(-req.d) : NUM_W'(req.d);

    // restoring division, one quotient bit per cycle
    assign rem_sh = {rem_reg[NUM_W-2:0], acc_reg[MAG_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, dmag_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MD_IDLE,
            MD_DONE:
            begin
                if (take)
                begin
                    state_next = (req.d == '0) ? MD_DONE : MD_MUL;
                end
                else
                begin
                    state_next = MD_IDLE;
                end
            end
            MD_MUL:
            begin
                if (cnt_reg == CNT_W'(NUM_W - 2))
                begin
                    state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    state_next = MD_DONE;
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        quot       = $signed({2'b00, acc_reg});
        resp.done  = (state_reg == MD_DONE);
        resp.fault = fault_reg;
        resp.res   = RES_W'(a_reg) - (neg_reg ? -quot : quot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // shift-add multiply, then divide
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            xsh_reg   <= MAG_W'(diff_mag);
            nmag_reg  <= n_abs[NUM_W-2:0];
            dmag_reg  <= d_abs[NUM_W-2:0];
            acc_reg   <= '0;
            rem_reg   <= '0;
            a_reg     <= req.a;
            neg_reg   <= diff[VAL_W-1] ^ req.n[NUM_W-1] ^ req.d[NUM_W-1];
            fault_reg <= (req.d == '0);
            cnt_reg   <= '0;
        end
        else if (state_reg == MD_MUL)
        begin
            if (nmag_reg[0])
            begin
                acc_reg <= acc_reg + xsh_reg;
            end
            xsh_reg  <= {xsh_reg[MAG_W-2:0], 1'b0};
            nmag_reg <= {1'b0, nmag_reg[NUM_W-2:1]};
            cnt_reg  <= (cnt_reg == CNT_W'(NUM_W - 2)) ? '0 : cnt_reg + 1'b1;
        end
        else if (state_reg == MD_DIV)
        begin
            rem_reg <= rem_ge ? (rem_sh - {1'b0, dmag_reg}) : rem_sh;
            acc_reg <= {acc_reg[MAG_W-2:0], rem_ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

endmodule

[design/sitp_back.sv]
module sitp_back #(
    parameter int MAX_DENSITY_ROWS    = sitp_pkg::MAX_DENSITY_ROWS_DEF,
    parameter int MAX_MOISTURE_POINTS = sitp_pkg::MAX_MOISTURE_POINTS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  sitp_pkg::item_t                            q_item,
    input  logic                                       q_valid,
    output logic                                       q_pop,
    input  logic [$clog2(MAX_DENSITY_ROWS+1)-1:0]      rows_used,
    input  logic [$clog2(MAX_MOISTURE_POINTS+1)-1:0]   pts_used,
    output sitp_pkg::step_req_t                        step_req,
    input  sitp_pkg::step_resp_t                       step_resp,
    output logic                                       result_valid,
    output logic [sitp_pkg::WORD_W-1:0]                impedance,
    output logic [1:0]                                 status
);
    import sitp_pkg::*;

    localparam int RCW   = $clog2(MAX_DENSITY_ROWS + 1);
    localparam int PCW   = $clog2(MAX_MOISTURE_POINTS + 1);
    localparam int RIW   = $clog2(MAX_DENSITY_ROWS);
    localparam int CIW   = $clog2(MAX_MOISTURE_POINTS);
    localparam int GRID  = MAX_DENSITY_ROWS * MAX_MOISTURE_POINTS;
    localparam int GAW   = $clog2(GRID);

    back_state_t         state_reg, state_next;
    item_t               item_reg;
    logic [WORD_W-1:0]   v_reg;
    logic                sat_reg;
    logic [RCW-1:0]      r_reg;
    logic [PCW-1:0]      k_reg;
    logic [RCW-1:0]      jj_reg;
    logic [PCW-1:0]      ik_reg;
    logic [FE_W-1:0]     fcnt_reg;
    logic [WORD_W-1:0]   fetch_reg [FE_COUNT];
    logic signed [VAL_W-1:0] p_reg;
    logic                result_valid_reg;
    logic [WORD_W-1:0]   impedance_reg;
    status_t             status_reg;

    // table memories
    logic [WORD_W-1:0]   g_mem [MAX_MOISTURE_POINTS];
    logic [WORD_W-1:0]   t_mem [GRID];
    logic [WORD_W-1:0]   m_mem [GRID];
    logic [WORD_W-1:0]   g_rdata_reg;
    logic [WORD_W-1:0]   t_rdata_reg;
    logic [WORD_W-1:0]   m_rdata_reg;
    logic [CIW-1:0]      g_raddr;
    logic [GAW-1:0]      t_raddr;
    logic [GAW-1:0]      m_raddr;
    logic                g_wen;
    logic                t_wen;
    logic                m_wen;
    logic [CIW-1:0]      w_col;
    logic [GAW-1:0]      w_gaddr;
    logic                row_ok;
    logic                col_ok;

    // bracketing indexes
    logic [RCW-1:0]      j1_full;
    logic [RCW-1:0]      j0_full;
    logic [PCW-1:0]      i1_full;
    logic [PCW-1:0]      i0_full;
    logic [RIW-1:0]      j0;
    logic [RIW-1:0]      j1;
    logic [CIW-1:0]      i0;
    logic [CIW-1:0]      i1;
    logic                at_point;
    logic                j1_zero;

    // control from the output block
    logic                emit;
    status_t             emit_status;
    logic                fin_en;
    logic signed [RES_W-1:0] fin_val;
    logic                fin_lo;
    logic                fin_hi;
    logic [FE_W-1:0]     cap_idx;
    logic [WORD_W-1:0]   cap_data;
    logic                ds_hit;
    logic                ms_hit;

    function automatic logic [GAW-1:0] grid_addr(input logic [RIW-1:0] row,
                                                 input logic [CIW-1:0] col);
        grid_addr = GAW'(row) * GAW'(MAX_MOISTURE_POINTS) + GAW'(col);
    endfunction

    // index clamping at the table ends
    assign j1_full  = (jj_reg == rows_used) ? rows_used - 1'b1 : jj_reg;
    assign j0_full  = (jj_reg == '0) ? '0 : jj_reg - 1'b1;
    assign i1_full  = (ik_reg == pts_used) ? pts_used - 1'b1 : ik_reg;
    assign i0_full  = (ik_reg == '0) ? '0 : ik_reg - 1'b1;
    assign j1       = j1_full[RIW-1:0];
    assign j0       = j0_full[RIW-1:0];
    assign i1       = i1_full[CIW-1:0];
    assign i0       = i0_full[CIW-1:0];
    assign j1_zero  = (j1 == '0);
    assign at_point = (i1 == '0) || (v_reg <= fetch_reg[FE_G1]);

    // write address checks
    assign row_ok  = (32'(item_reg.table_row) < MAX_DENSITY_ROWS);
    assign col_ok  = (32'(item_reg.table_col) < MAX_MOISTURE_POINTS);
    assign w_col   = CIW'(item_reg.table_col);
    assign w_gaddr = grid_addr(RIW'(item_reg.table_row), w_col);

    // search compares
    assign ds_hit = (item_reg.bulk_density <= t_rdata_reg);
    assign ms_hit = (v_reg <= g_rdata_reg);

    // fetched data comes from the memory the slot belongs to
    assign cap_idx  = fcnt_reg - 1'b1;
    always_comb
    begin
        if (cap_idx <= FE_G1)
        begin
            cap_data = g_rdata_reg;
        end
        else if (cap_idx <= FE_M_J1I1)
        begin
            cap_data = m_rdata_reg;
        end
        else
        begin
            cap_data = t_rdata_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_DISPATCH;
                end
            end
            BK_DISPATCH:
            begin
                if (item_reg.kind != KIND_COMPUTE || item_reg.bulk_density == '0)
                begin
                    state_next = BK_IDLE;
                end
                else
                begin
                    state_next = BK_RATIO;
                end
            end
            BK_RATIO:
            begin
                if (step_resp.done)
                begin
                    state_next = BK_DS_RD;
                end
            end
            BK_DS_RD:
            begin
                state_next = (r_reg == rows_used) ? BK_MS_RD : BK_DS_CMP;
            end
            BK_DS_CMP:
            begin
                state_next = ds_hit ? BK_MS_RD : BK_DS_RD;
            end
            BK_MS_RD:
            begin
                state_next = (k_reg == pts_used) ? BK_FETCH : BK_MS_CMP;
            end
            BK_MS_CMP:
            begin
                state_next = ms_hit ? BK_FETCH : BK_MS_RD;
            end
            BK_FETCH:
            begin
                if (fcnt_reg == FE_END)
                begin
                    state_next = BK_EVAL;
                end
            end
            BK_EVAL:
            begin
                if (j1_zero)
                begin
                    state_next = at_point ? BK_IDLE : BK_STEP_LAST;
                end
                else
                begin
                    state_next = BK_STEP_P;
                end
            end
            BK_STEP_P:
            begin
                if (step_resp.done)
                begin
                    state_next = (step_resp.fault || at_point) ? BK_IDLE : BK_STEP_Q;
                end
            end
            BK_STEP_Q:
            begin
                if (step_resp.done)
                begin
                    state_next = step_resp.fault ? BK_IDLE : BK_STEP_LAST;
                end
            end
            BK_STEP_LAST:
            begin
                if (step_resp.done)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs: pops, memory ports, step requests, results
    always_comb
    begin
        q_pop          = 1'b0;
        g_wen          = 1'b0;
        t_wen          = 1'b0;
        m_wen          = 1'b0;
        g_raddr        = '0;
        t_raddr        = '0;
        m_raddr        = '0;
        step_req.start = 1'b0;
        step_req.a     = '0;
        step_req.b     = '0;
        step_req.n     = '0;
        step_req.d     = '0;
        emit           = 1'b0;
        emit_status    = ST_FAULT;
        fin_en         = 1'b0;
        fin_val        = '0;
        unique case (state_reg)
            BK_IDLE:
            begin
                q_pop = q_valid;
            end
            BK_DISPATCH:
            begin
                if (item_reg.kind != KIND_COMPUTE)
                begin
                    g_wen       = (item_reg.kind == KIND_WR_BREAK) && col_ok;
                    t_wen       = (item_reg.kind == KIND_WR_DENSITY) && row_ok && col_ok;
                    m_wen       = (item_reg.kind == KIND_WR_IMPED) && row_ok && col_ok;
                    emit        = 1'b1;
                    emit_status = ST_WRITE;
                end
                else if (item_reg.bulk_density == '0)
                begin
                    emit        = 1'b1;
                    emit_status = ST_FAULT;
                end
                else
                begin
                    // moisture ratio as 0 - (0 - water*4096) / density
                    step_req.start = 1'b1;
                    step_req.a     = '0;
                    step_req.b     = $signed(VAL_W'({item_reg.water_content, 12'b0}));
                    step_req.n     = NUM_W'(1);
                    step_req.d     = $signed({1'b0, item_reg.bulk_density});
                end
            end
            BK_DS_RD:
            begin
                t_raddr = grid_addr(RIW'(r_reg), '0);
            end
            BK_MS_RD:
            begin
                g_raddr = CIW'(k_reg);
            end
            BK_FETCH:
            begin
                unique case (fcnt_reg)
                    FE_G0:     g_raddr = i0;
                    FE_G1:     g_raddr = i1;
                    FE_M_J0I0: m_raddr = grid_addr(j0, i0);
                    FE_M_J0I1: m_raddr = grid_addr(j0, i1);
                    FE_M_J1I1: m_raddr = grid_addr(j1, i1);
                    FE_T_J0I0: t_raddr = grid_addr(j0, i0);
                    FE_T_J0I1: t_raddr = grid_addr(j0, i1);
                    FE_T_J1I0: t_raddr = grid_addr(j1, i0);
                    FE_T_J1I1: t_raddr = grid_addr(j1, i1);
                    default:   t_raddr = '0;
                endcase
            end
            BK_EVAL:
            begin
                if (j1_zero && at_point)
                begin
                    fin_en  = 1'b1;
                    fin_val = RES_W'(word_val(fetch_reg[FE_M_J1I1]));
                end
                else if (j1_zero)
                begin
                    // moisture interpolation along the first row
                    step_req.start = 1'b1;
                    step_req.a     = word_val(fetch_reg[FE_M_J0I0]);
                    step_req.b     = word_val(fetch_reg[FE_M_J1I1]);
                    step_req.n     = word_diff(v_reg, fetch_reg[FE_G0]);
                    step_req.d     = word_diff(fetch_reg[FE_G1], fetch_reg[FE_G0]);
                end
                else
                begin
                    // density interpolation at the upper moisture point
                    step_req.start = 1'b1;
                    step_req.a     = word_val(fetch_reg[FE_M_J0I1]);
                    step_req.b     = word_val(fetch_reg[FE_M_J1I1]);
                    step_req.n     = word_diff(fetch_reg[FE_T_J0I1], item_reg.bulk_density);
                    step_req.d     = word_diff(fetch_reg[FE_T_J0I1], fetch_reg[FE_T_J1I1]);
                end
            end
            BK_STEP_P:
            begin
                if (step_resp.done)
                begin
                    if (step_resp.fault)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_FAULT;
                    end
                    else if (at_point)
                    begin
                        fin_en  = 1'b1;
                        fin_val = step_resp.res;
                    end
                    else
                    begin
                        // density interpolation at the lower moisture point
                        step_req.start = 1'b1;
                        step_req.a     = word_val(fetch_reg[FE_M_J0I0]);
                        step_req.b     = word_val(fetch_reg[FE_M_J1I1]);
                        step_req.n     = word_diff(fetch_reg[FE_T_J0I0], item_reg.bulk_density);
                        step_req.d     = word_diff(fetch_reg[FE_T_J0I0], fetch_reg[FE_T_J1I0]);
                    end
                end
            end
            BK_STEP_Q:
            begin
                if (step_resp.done)
                begin
                    if (step_resp.fault)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_FAULT;
                    end
                    else
                    begin
                        // blend q toward p across the moisture interval
                        step_req.start = 1'b1;
                        step_req.a     = step_resp.res[VAL_W-1:0];
                        step_req.b     = p_reg;
                        step_req.n     = word_diff(v_reg, fetch_reg[FE_G0]);
                        step_req.d     = word_diff(fetch_reg[FE_G1], fetch_reg[FE_G0]);
                    end
                end
            end
            BK_STEP_LAST:
            begin
                if (step_resp.done)
                begin
                    if (step_resp.fault)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_FAULT;
                    end
                    else
                    begin
                        fin_en  = 1'b1;
                        fin_val = step_resp.res;
                    end
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // final value clipping
    assign fin_lo = fin_val[RES_W-1];
    assign fin_hi = !fin_val[RES_W-1] && (fin_val > $signed(RES_W'(16'hFFFF)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= emit || fin_en;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (emit)
        begin
            impedance_reg <= '0;
            status_reg    <= emit_status;
        end
        else if (fin_en)
        begin
            impedance_reg <= fin_lo ? '0 : (fin_hi ? 16'hFFFF : fin_val[WORD_W-1:0]);
            status_reg    <= (sat_reg || fin_lo || fin_hi) ? ST_SAT : ST_OK;
        end
        unique case (state_reg)
            BK_RATIO:
            begin
                if (step_resp.done)
                begin
                    if (step_resp.res > $signed(RES_W'(16'hFFFF)))
                    begin
                        v_reg   <= 16'hFFFF;
                        sat_reg <= 1'b1;
                    end
                    else
                    begin
                        v_reg   <= step_resp.res[WORD_W-1:0];
                        sat_reg <= 1'b0;
                    end
                    r_reg <= '0;
                end
            end
            BK_DS_RD:
            begin
                if (r_reg == rows_used)
                begin
                    jj_reg <= rows_used;
                    k_reg  <= '0;
                end
            end
            BK_DS_CMP:
            begin
                if (ds_hit)
                begin
                    jj_reg <= r_reg;
                    k_reg  <= '0;
                end
                else
                begin
                    r_reg <= r_reg + 1'b1;
                end
            end
            BK_MS_RD:
            begin
                if (k_reg == pts_used)
                begin
                    ik_reg   <= pts_used;
                    fcnt_reg <= '0;
                end
            end
            BK_MS_CMP:
            begin
                if (ms_hit)
                begin
                    ik_reg   <= k_reg;
                    fcnt_reg <= '0;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            BK_FETCH:
            begin
                fcnt_reg <= fcnt_reg + 1'b1;
                if (fcnt_reg != '0)
                begin
                    fetch_reg[cap_idx] <= cap_data;
                end
            end
            BK_STEP_P:
            begin
                if (step_resp.done)
                begin
                    p_reg <= step_resp.res[VAL_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // moisture break memory
    always_ff @(posedge clk)
    begin
        if (g_wen)
        begin
            g_mem[w_col] <= item_reg.table_word;
        end
        g_rdata_reg <= g_mem[g_raddr];
    end

    // density grid memory
    always_ff @(posedge clk)
    begin
        if (t_wen)
        begin
            t_mem[w_gaddr] <= item_reg.table_word;
        end
        t_rdata_reg <= t_mem[t_raddr];
    end

    // impedance grid memory
    always_ff @(posedge clk)
    begin
        if (m_wen)
        begin
            m_mem[w_gaddr] <= item_reg.table_word;
        end
        m_rdata_reg <= m_mem[m_raddr];
    end

    assign result_valid = result_valid_reg;
    assign impedance    = impedance_reg;
    assign status       = status_reg;

endmodule

[design/soil_impedance_table_interpolator_top.sv]
// Soil impedance table interpolator. Issue an item with start while busy is low;
// kind selects a table write (moisture break, density entry, impedance entry) or a
// compute of impedance from bulk density and water content. Every item gives exactly
// one result on result_valid, impedance and status, held for one cycle; the receiver
// cannot stall, so results must be taken as they come. A two-item queue sits in front
// of the sequencer, and busy rises only when it is full. A compute runs the moisture
// ratio and each of up to three interpolation steps through one shared multiply-divide
// unit that works one bit per cycle, the two breakpoint searches read and compare one
// table entry at a time, and the operand fetch reads its operands from the tables one
// slot at a time. Tables must be written before a compute reads them. Configuration
// writes are taken at any time but belong between items.
module soil_impedance_table_interpolator_top #(
    parameter int MAX_DENSITY_ROWS    = sitp_pkg::MAX_DENSITY_ROWS_DEF,
    parameter int MAX_MOISTURE_POINTS = sitp_pkg::MAX_MOISTURE_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sitp_pkg::KIND_W-1:0]   kind,
    input  logic [sitp_pkg::IDX_W-1:0]    table_row,
    input  logic [sitp_pkg::IDX_W-1:0]    table_col,
    input  logic [sitp_pkg::WORD_W-1:0]   table_word,
    input  logic [sitp_pkg::WORD_W-1:0]   bulk_density,
    input  logic [sitp_pkg::WORD_W-1:0]   water_content,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [sitp_pkg::CFG_W-1:0]    cfg_data,
    output logic                          result_valid,
    output logic [sitp_pkg::WORD_W-1:0]   impedance,
    output logic [1:0]                    status
);
    import sitp_pkg::*;

    localparam int RCW = $clog2(MAX_DENSITY_ROWS + 1);
    localparam int PCW = $clog2(MAX_MOISTURE_POINTS + 1);

    logic [CFG_W-1:0] rows_cfg_reg;
    logic [CFG_W-1:0] pts_cfg_reg;
    logic [RCW-1:0]   rows_used;
    logic [PCW-1:0]   pts_used;
    item_t            in_item;
    item_t            q_item;
    logic             q_valid;
    logic             q_pop;
    step_req_t        step_req;
    step_resp_t       step_resp;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= CFG_RESET;
            pts_cfg_reg  <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DENSITY_ROWS: rows_cfg_reg <= cfg_data;
                CFG_MOISTURE_PTS: pts_cfg_reg  <= cfg_data;
                default:          rows_cfg_reg <= rows_cfg_reg;
            endcase
        end
    end

    // counts clamped to one and to the table size
    always_comb
    begin
        if (rows_cfg_reg == '0)
        begin
            rows_used = RCW'(1);
        end
        else if (32'(rows_cfg_reg) > MAX_DENSITY_ROWS)
        begin
            rows_used = RCW'(MAX_DENSITY_ROWS);
        end
        else
        begin
            rows_used = RCW'(rows_cfg_reg);
        end
        if (pts_cfg_reg == '0)
        begin
            pts_used = PCW'(1);
        end
        else if (32'(pts_cfg_reg) > MAX_MOISTURE_POINTS)
        begin
            pts_used = PCW'(MAX_MOISTURE_POINTS);
        end
        else
        begin
            pts_used = PCW'(pts_cfg_reg);
        end
    end

    // input item assembly
    assign in_item.kind          = kind_t'(kind);
    assign in_item.table_row     = table_row;
    assign in_item.table_col     = table_col;
    assign in_item.table_word    = table_word;
    assign in_item.bulk_density  = bulk_density;
    assign in_item.water_content = water_content;

    sitp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .in_item (in_item),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    sitp_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (step_req),
        .resp  (step_resp)
    );

    sitp_back #(
        .MAX_DENSITY_ROWS    (MAX_DENSITY_ROWS),
        .MAX_MOISTURE_POINTS (MAX_MOISTURE_POINTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .rows_used    (rows_used),
        .pts_used     (pts_used),
        .step_req     (step_req),
        .step_resp    (step_resp),
        .result_valid (result_valid),
        .impedance    (impedance),
        .status       (status)
    );

endmodule

[verif/soil_impedance_table_interpolator_checker.sv]
`timescale 1ns / 1ps

module soil_impedance_table_interpolator_checker
    import sitp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [KIND_W-1:0]   kind,
    input  logic [IDX_W-1:0]    table_row,
    input  logic [IDX_W-1:0]    table_col,
    input  logic [WORD_W-1:0]   table_word,
    input  logic [WORD_W-1:0]   bulk_density,
    input  logic [WORD_W-1:0]   water_content,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                result_valid,
    input  logic [WORD_W-1:0]   impedance,
    input  logic [1:0]          status,
    output int                  fail_count,
    output int                  pending
);

    // shadow copy of the tables and registers
    logic [WORD_W-1:0] breaks_sh [8];
    logic [WORD_W-1:0] dens_sh [8][8];
    logic [WORD_W-1:0] imp_sh [8][8];
    logic [CFG_W-1:0]  rows_reg;
    logic [CFG_W-1:0]  pts_reg;

    typedef struct {
        logic [WORD_W-1:0] imp;
        status_t           st;
    } cell_result_t;

    cell_result_t expected_cells [$];

    function automatic int clamp_count(input logic [CFG_W-1:0] v);
        if (v < 1) return 1;
        if (v > 8) return 8;
        return int'(v);
    endfunction

    // a - (a - b) * n / d into r; returns 0 with no result when d is zero
    function automatic bit interp_step(input longint a, input longint b, input longint n,
                                       input longint d, output longint r);
        if (d == 0) return 1'b0;
        r = a - ((a - b) * n) / d;
        return 1'b1;
    endfunction

    function automatic cell_result_t predict_cell(input logic [WORD_W-1:0] dens,
                                                  input logic [WORD_W-1:0] water);
        cell_result_t cr;
        int rows, pts, jj, ik, j0, j1, i0, i1;
        longint v, d, g0, g1, p, q, res, vq;
        bit sat, ok, at_point;
        cr.imp = '0;
        cr.st  = ST_FAULT;
        sat = 1'b0;
        ok = 1'b1;
        res = 0;
        if (dens == 0) return cr;
        rows = clamp_count(rows_reg);
        pts  = clamp_count(pts_reg);
        vq = (longint'(water) << 12) / longint'(dens);
        if (vq > 65535) begin
            vq = 65535;
            sat = 1'b1;
        end
        v = vq;
        d = longint'(dens);
        // bracketing search over density column 0 and moisture breaks
        for (jj = 0; jj < rows; jj++)
            if (d <= longint'(dens_sh[jj][0])) break;
        j1 = (jj > rows - 1) ? rows - 1 : jj;
        j0 = (jj - 1 < 0) ? 0 : jj - 1;
        for (ik = 0; ik < pts; ik++)
            if (v <= longint'(breaks_sh[ik])) break;
        i1 = (ik > pts - 1) ? pts - 1 : ik;
        i0 = (ik - 1 < 0) ? 0 : ik - 1;
        g0 = longint'(breaks_sh[i0]);
        g1 = longint'(breaks_sh[i1]);
        at_point = (i1 == 0) || (v <= g1);
        if (j1 == 0) begin
            if (at_point) res = longint'(imp_sh[j1][i1]);
            else ok = interp_step(imp_sh[j1][i0], imp_sh[j1][i1], v - g0, g1 - g0, res);
        end
        else begin
            ok = interp_step(imp_sh[j0][i1], imp_sh[j1][i1],
                             longint'(dens_sh[j0][i1]) - d,
                             longint'(dens_sh[j0][i1]) - longint'(dens_sh[j1][i1]), p);
            if (ok && at_point) res = p;
            else if (ok) begin
                ok = interp_step(imp_sh[j0][i0], imp_sh[j1][i1],
                                 longint'(dens_sh[j0][i0]) - d,
                                 longint'(dens_sh[j0][i0]) - longint'(dens_sh[j1][i0]), q);
                if (ok) begin
                    if (g1 - g0 == 0) ok = 1'b0;
                    else res = q + ((p - q) * (v - g0)) / (g1 - g0);
                end
            end
        end
        if (!ok) return cr;
        if (res < 0) begin
            res = 0;
            sat = 1'b1;
        end
        else if (res > 65535) begin
            res = 65535;
            sat = 1'b1;
        end
        cr.imp = res[WORD_W-1:0];
        cr.st  = sat ? ST_SAT : ST_OK;
        return cr;
    endfunction

    assign pending = expected_cells.size();

    // watch the item, register and result channels
    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t cr;
        if (!rst_n) begin
            rows_reg   <= CFG_RESET;
            pts_reg    <= CFG_RESET;
            fail_count <= 0;
            expected_cells.delete();
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_DENSITY_ROWS) rows_reg <= cfg_data;
                else pts_reg <= cfg_data;
            end
            if (result_valid) begin
                if (expected_cells.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: impedance %h status %0d",
                                 impedance, status);
                    fail_count <= fail_count + 1;
                end
                else begin
                    cr = expected_cells.pop_front();
                    if (impedance !== cr.imp || status !== cr.st) begin
                        if (fail_count < 10)
                            $display("mismatch: exp impedance %h status %0d, got %h %0d",
                                     cr.imp, cr.st, impedance, status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                case (kind_t'(kind))
                    KIND_WR_BREAK:   breaks_sh[table_col] = table_word;
                    KIND_WR_DENSITY: dens_sh[table_row][table_col] = table_word;
                    KIND_WR_IMPED:   imp_sh[table_row][table_col] = table_word;
                    default: ;
                endcase
                if (kind_t'(kind) == KIND_COMPUTE)
                    cr = predict_cell(bulk_density, water_content);
                else begin
                    cr.imp = '0;
                    cr.st  = ST_WRITE;
                end
                expected_cells.push_back(cr);
            end
        end
    end

endmodule

[verif/soil_impedance_table_interpolator_top_tb.sv]
`timescale 1ns / 1ps

module soil_impedance_table_interpolator_top_tb;
    import sitp_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [KIND_W-1:0]   kind;
    logic [IDX_W-1:0]    table_row;
    logic [IDX_W-1:0]    table_col;
    logic [WORD_W-1:0]   table_word;
    logic [WORD_W-1:0]   bulk_density;
    logic [WORD_W-1:0]   water_content;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                result_valid;
    logic [WORD_W-1:0]   impedance;
    logic [1:0]          status;
    int                  fail_count;
    int                  pending;
    int                  idle_pct;
    int                  quiet_cycles;

    soil_impedance_table_interpolator_top dut (.*);

    soil_impedance_table_interpolator_checker chk (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("soil_impedance_table_interpolator_top_tb failed");
            $finish;
        end
    end

    // issue one item, holding start across back-to-back items
    task automatic send_item(input kind_t k, input logic [IDX_W-1:0] r,
                             input logic [IDX_W-1:0] c, input logic [WORD_W-1:0] w,
                             input logic [WORD_W-1:0] dens, input logic [WORD_W-1:0] water);
        int gap;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        else @(negedge clk);
        start         = 1'b1;
        kind          = k;
        table_row     = r;
        table_col     = c;
        table_word    = w;
        bulk_density  = dens;
        water_content = water;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain_items();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // well-formed tables rise with index; noise tables mix 0, FFFF, 4000 and random words
    function automatic logic [WORD_W-1:0] table_value(input bit noisy, input int pos);
        if (noisy) begin
            case ($urandom_range(3))
                0: return '0;
                1: return 16'hFFFF;
                2: return 16'h4000;
                default: return WORD_W'($urandom);
            endcase
        end
        return WORD_W'(pos * 16'h2000 + $urandom_range(16'h1FFF));
    endfunction

    task automatic load_tables(input bit noisy);
        for (int c = 0; c < 8; c++)
            send_item(KIND_WR_BREAK, IDX_W'($urandom), IDX_W'(c),
                      table_value(noisy, c), WORD_W'($urandom), WORD_W'($urandom));
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < 8; c++) begin
                send_item(KIND_WR_DENSITY, IDX_W'(r), IDX_W'(c), table_value(noisy, r),
                          WORD_W'($urandom), WORD_W'($urandom));
                send_item(KIND_WR_IMPED, IDX_W'(r), IDX_W'(c), WORD_W'($urandom),
                          WORD_W'($urandom), WORD_W'($urandom));
            end
    endtask

    task automatic random_items(input int count, input bit noisy);
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 15) begin
                sel = $urandom_range(7);
                send_item(KIND_WR_BREAK, IDX_W'($urandom), IDX_W'(sel),
                          table_value(noisy, sel), WORD_W'($urandom), WORD_W'($urandom));
            end
            else if (sel < 22) begin
                sel = $urandom_range(7);
                send_item(KIND_WR_DENSITY, IDX_W'(sel), IDX_W'($urandom),
                          table_value(noisy, sel), WORD_W'($urandom), WORD_W'($urandom));
            end
            else if (sel < 30)
                send_item(KIND_WR_IMPED, IDX_W'($urandom), IDX_W'($urandom),
                          WORD_W'($urandom), WORD_W'($urandom), WORD_W'($urandom));
            else if (sel < 38)
                send_item(KIND_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), WORD_W'($urandom),
                          WORD_W'($urandom_range(16'h40)), WORD_W'($urandom));
            else
                send_item(KIND_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), WORD_W'($urandom),
                          WORD_W'($urandom), WORD_W'($urandom));
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] rows_set [6];
        logic [CFG_W-1:0] pts_set [6];
        rows_set = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8};
        pts_set  = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd5, 4'd2};
        start = 1'b0;
        kind = KIND_COMPUTE;
        table_row = '0;
        table_col = '0;
        table_word = '0;
        bulk_density = '0;
        water_content = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DENSITY_ROWS;
        cfg_data = '0;
        quiet_cycles = 0;
        idle_pct = 11;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, zero density, ratio overflow, table ends
        write_reg(CFG_DENSITY_ROWS, 4'd8);
        write_reg(CFG_MOISTURE_PTS, 4'd8);
        load_tables(1'b0);
        send_item(KIND_COMPUTE, '0, '0, '0, 16'h0000, 16'h1234);
        send_item(KIND_COMPUTE, '1, '1, '1, 16'h0001, 16'hFFFF);
        send_item(KIND_COMPUTE, '0, '0, '0, 16'hFFFF, 16'h0000);
        send_item(KIND_COMPUTE, '0, '0, '0, 16'hFFFF, 16'hFFFF);
        send_item(KIND_COMPUTE, '0, '0, '0, 16'h0001, 16'h0000);
        send_item(KIND_COMPUTE, '0, '0, '0, 16'h1000, 16'h0800);
        send_item(KIND_COMPUTE, '0, '0, '0, 16'h7000, 16'h3000);
        send_item(KIND_COMPUTE, '0, '0, '0, 16'hC000, 16'hF000);
        send_item(KIND_WR_BREAK, '1, '1, 16'hFFFF, '1, '1);
        send_item(KIND_WR_DENSITY, '1, '1, 16'hFFFF, '1, '1);
        send_item(KIND_WR_IMPED, '1, '1, 16'hFFFF, '1, '1);
        send_item(KIND_COMPUTE, '0, '0, '0, 16'h2000, 16'h9000);

        // phases over register settings and idle profiles
        for (int ph = 0; ph < 6; ph++) begin
            drain_items();
            idle_pct = (ph < 2) ? 11 : (ph < 4) ? 60 : 0;
            write_reg(CFG_DENSITY_ROWS, rows_set[ph]);
            write_reg(CFG_MOISTURE_PTS, pts_set[ph]);
            if (ph == 3) load_tables(1'b1);
            else if (ph == 4) load_tables(1'b0);
            random_items(45, ph == 3);
            // in phase 1, the sender holds off until everything is back
            if (ph == 1) drain_items();
            random_items(45, ph == 3);
        end

        drain_items();
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("soil_impedance_table_interpolator_top_tb passed");
        else
            $display("soil_impedance_table_interpolator_top_tb failed");
        $finish;
    end

endmodule

[filelist.f]
design/sitp_pkg.sv
design/sitp_front.sv
design/sitp_step.sv
design/sitp_back.sv
design/soil_impedance_table_interpolator_top.sv
verif/soil_impedance_table_interpolator_checker.sv
verif/soil_impedance_table_interpolator_top_tb.sv
